// ===== hw/rtl/piecewise_cubic_evaluator_defines.svh =====
// Assertion helpers for the piecewise cubic evaluator.
`ifndef PIECEWISE_CUBIC_EVALUATOR_DEFINES_SVH
`define PIECEWISE_CUBIC_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define PCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pce: same-cycle check failed");
// Next-cycle implication, disabled while in reset.
`define PCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pce: next-cycle check failed");
`else
`define PCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/pce_pkg.sv =====
package pce_pkg;

    localparam int MAX_KNOTS  = 32;
    localparam int KNOT_IDX_W = 5;
    localparam int NUM_SEGS   = MAX_KNOTS - 1;
    localparam int SEG_W      = 5;
    localparam int COEF_IDX_W = 7;
    localparam int NUM_W      = 6;
    localparam int OP_W       = 2;
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_W    = 48;

    // Horner datapath: 33x32 signed limb products into a 128-bit accumulator
    localparam int LIMB_W     = DATA_W + 1;
    localparam int MUL_W      = LIMB_W + DATA_W;
    localparam int H_W        = 3 * DATA_W;
    localparam int ACC_W      = 4 * DATA_W;
    localparam int RND_LSB    = 3 * FRAC_BITS;

    localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (RND_LSB - 1);
    localparam logic [VALUE_W-1:0] SAT_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] SAT_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_KNOT = 2'd0,
        OP_LOAD_COEF = 2'd1,
        OP_EVAL      = 2'd2
    } op_t;

    typedef struct packed {
        logic x_ge;   // query at or above this knot
        logic x_le;   // query at or below this knot
        logic encl;   // this knot and the next enclose the query
    } cell_flags_t;

endpackage

// ===== hw/rtl/piecewise_cubic_evaluator.sv =====
// Piecewise cubic evaluator. Knots and coefficients are loaded one transaction at a
// time; an evaluate transaction searches the knot row for the segment of the query
// point, fetches that segment's four coefficients and runs a Horner sequence on one
// shared 33x32 multiplier, seven limb products, each a multiply state then an add state.
// No transaction is accepted while an evaluate is in progress; the input side is ready
// again in the cycle the result is registered, and a waiting result does not block the
// next transaction from being accepted.
`include "piecewise_cubic_evaluator_defines.svh"

module piecewise_cubic_evaluator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [pce_pkg::NUM_W-1:0]            cfg_wdata,   // num_points
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pce_pkg::S_TDATA_W-1:0]        s_tdata,     // entry_index, entry_value, query_x
    input  logic [pce_pkg::OP_W-1:0]             s_tuser,     // operation
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pce_pkg::M_TDATA_W-1:0]        m_tdata,     // value_out, segment_used
    output logic [0:0]                           m_tuser      // overflowed
);
    import pce_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CMP   = 5'b00010,
        ST_SEL   = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_CALC  = 5'b10000
    } ctrl_state_t;

    ctrl_state_t              state_reg, state_next;
    logic [NUM_W-1:0]         cfg_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [SEG_W-1:0]         seg_reg;
    logic                     start_reg;
    logic signed [DATA_W-1:0] coef_rd_reg [4];
    logic [DATA_W-1:0]        coef_mem [4][MAX_KNOTS];

    logic                     m_tvalid_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic                     ovf_reg;
    logic [SEG_W-1:0]         seg_out_reg;

    logic [COEF_IDX_W-1:0]    entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] query_x;
    logic                     accept;
    logic                     knot_we;
    logic                     coef_we;

    logic [MAX_KNOTS:0]       le_chain;
    cell_flags_t              cell_flags [MAX_KNOTS];

    logic [NUM_W-1:0]         n_act;
    logic [KNOT_IDX_W-1:0]    last_idx;
    logic [SEG_W-1:0]         seg_max;
    logic [NUM_SEGS-1:0]      encl_vec;
    logic [NUM_SEGS-1:0]      encl_low;
    logic [SEG_W-1:0]         seg_hit;
    logic [SEG_W-1:0]         seg_sel;

    logic                     out_free;
    logic                     calc_done;
    logic [VALUE_W-1:0]       calc_value;
    logic                     calc_ovf;

    assign entry_index = s_tdata[COEF_IDX_W-1:0];
    assign entry_value = s_tdata[COEF_IDX_W+DATA_W-1:COEF_IDX_W];
    assign query_x     = s_tdata[COEF_IDX_W+2*DATA_W-1:COEF_IDX_W+DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign knot_we  = accept && (s_tuser == OP_LOAD_KNOT)
                      && (entry_index < COEF_IDX_W'(MAX_KNOTS));
    assign coef_we  = accept && (s_tuser == OP_LOAD_COEF);

    // Knot row: cell j holds knot j and compares it against the held query.
    assign le_chain[MAX_KNOTS] = 1'b0;

    for (genvar j = 0; j < MAX_KNOTS; j++)
    begin : g_cell
        pce_knot_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .knot_we    (knot_we && (entry_index[KNOT_IDX_W-1:0] == KNOT_IDX_W'(j))),
            .knot_wdata (entry_value),
            .x          (x_reg),
            .le_next    (le_chain[j+1]),
            .le_here    (le_chain[j]),
            .flags      (cell_flags[j])
        );
    end

    // Clamp the knot count to between 2 and the table size.
    always_comb
    begin
        if (cfg_reg < NUM_W'(2))
        begin
            n_act = NUM_W'(2);
        end
        else if (cfg_reg > NUM_W'(MAX_KNOTS))
        begin
            n_act = NUM_W'(MAX_KNOTS);
        end
        else
        begin
            n_act = cfg_reg;
        end
    end

    assign last_idx = KNOT_IDX_W'(n_act - NUM_W'(1));
    assign seg_max  = SEG_W'(n_act - NUM_W'(2));

    always_comb
    begin
        for (int j = 0; j < NUM_SEGS; j++)
        begin
            encl_vec[j] = cell_flags[j].encl && (KNOT_IDX_W'(j) < last_idx);
        end
    end

    // Isolate the lowest enclosing segment, then encode it.
    assign encl_low = encl_vec & (~encl_vec + NUM_SEGS'(1));

    always_comb
    begin
        seg_hit = '0;
        for (int j = 0; j < NUM_SEGS; j++)
        begin
            if (encl_low[j])
            begin
                seg_hit = seg_hit | SEG_W'(j);
            end
        end
    end

    always_comb
    begin
        if (cell_flags[0].x_le)
        begin
            seg_sel = '0;
        end
        else if (cell_flags[last_idx].x_ge)
        begin
            seg_sel = seg_max;
        end
        else if (|encl_vec)
        begin
            seg_sel = seg_hit;
        end
        else
        begin
            seg_sel = seg_max;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_EVAL))
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:   state_next = ST_SEL;
            ST_SEL:   state_next = ST_FETCH;
            ST_FETCH: state_next = ST_CALC;
            ST_CALC:
            begin
                if (calc_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= NUM_W'(2);
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_FETCH);
            if (cfg_wen)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (calc_done)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Coefficient store: one bank per power slot, addressed by segment.
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[entry_index[1:0]][entry_index[COEF_IDX_W-1:2]] <= entry_value;
        end
        if (state_reg == ST_FETCH)
        begin
            for (int b = 0; b < 4; b++)
            begin
                coef_rd_reg[b] <= coef_mem[b][seg_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_tuser == OP_EVAL))
        begin
            x_reg <= query_x;
        end
        if (state_reg == ST_SEL)
        begin
            seg_reg <= seg_sel;
        end
        if (calc_done)
        begin
            value_reg   <= calc_value;
            ovf_reg     <= calc_ovf;
            seg_out_reg <= seg_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    pce_horner u_horner (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_reg),
        .out_free   (out_free),
        .x          (x_reg),
        .coef_a     (coef_rd_reg[0]),
        .coef_b     (coef_rd_reg[1]),
        .coef_c     (coef_rd_reg[2]),
        .coef_d     (coef_rd_reg[3]),
        .done       (calc_done),
        .value      (calc_value),
        .overflowed (calc_ovf)
    );

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {(M_TDATA_W-VALUE_W-SEG_W)'(0), seg_out_reg, value_reg};
    assign m_tuser[0] = ovf_reg;

    `PCE_ASSERT_NXT(a_eval_starts_search, clk, rst_n, accept && s_tuser == OP_EVAL, state_reg == ST_CMP)
    `PCE_ASSERT_NXT(a_seg_in_range, clk, rst_n, state_reg == ST_SEL, seg_reg <= seg_max)
    `PCE_ASSERT_IMP(a_done_needs_room, clk, rst_n, calc_done, out_free && state_reg == ST_CALC)
    `PCE_ASSERT_IMP(a_result_from_calc, clk, rst_n, $rose(m_tvalid_reg), $past(state_reg == ST_CALC))

endmodule

// ===== hw/rtl/pce_knot_cell.sv =====
module pce_knot_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              knot_we,
    input  logic signed [pce_pkg::DATA_W-1:0] knot_wdata,
    input  logic signed [pce_pkg::DATA_W-1:0] x,
    input  logic                              le_next,
    output logic                              le_here,
    output pce_pkg::cell_flags_t              flags
);
    import pce_pkg::*;

    logic signed [DATA_W-1:0] knot_reg;
    cell_flags_t              flags_reg;
    cell_flags_t              flags_next;

    always_ff @(posedge clk)
    begin
        if (knot_we)
        begin
            knot_reg <= knot_wdata;
        end
    end

    // Hand the at-or-below result to the lower neighbor; combine with the upper one.
    assign le_here = (x <= knot_reg);

    always_comb
    begin
        flags_next.x_ge = (x >= knot_reg);
        flags_next.x_le = le_here;
        flags_next.encl = flags_next.x_ge && le_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== hw/rtl/pce_horner.sv =====
`include "piecewise_cubic_evaluator_defines.svh"

module pce_horner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               out_free,
    input  logic signed [pce_pkg::DATA_W-1:0]  x,
    input  logic signed [pce_pkg::DATA_W-1:0]  coef_a,
    input  logic signed [pce_pkg::DATA_W-1:0]  coef_b,
    input  logic signed [pce_pkg::DATA_W-1:0]  coef_c,
    input  logic signed [pce_pkg::DATA_W-1:0]  coef_d,
    output logic                               done,
    output logic        [pce_pkg::VALUE_W-1:0] value,
    output logic                               overflowed
);
    import pce_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_MUL  = 4'b0010,
        C_ADD  = 4'b0100,
        C_RND  = 4'b1000
    } calc_state_t;

    calc_state_t              state_reg, state_next;
    logic [1:0]               step_reg, step_next;
    logic [1:0]               limb_reg, limb_next;
    logic [H_W-1:0]           m_reg, m_next;
    logic [ACC_W-1:0]         r_reg, r_next;
    logic signed [MUL_W-1:0]  prod_reg;

    logic [DATA_W-1:0]        limb;
    logic                     limb_signed;
    logic signed [LIMB_W-1:0] limb_ext;
    logic signed [MUL_W-1:0]  product;
    logic signed [ACC_W-1:0]  prod_ext;
    logic [ACC_W-1:0]         addend;
    logic [ACC_W-1:0]         sum;
    logic [1:0]               last_limb;
    logic signed [ACC_W-1:0]  init_b, init_c, init_d;
    logic [ACC_W-1:0]         rnd;
    logic                     fits;

    // Lower limbs are unsigned; the top limb, and the lone limb of step 0, is signed.
    always_comb
    begin
        case (limb_reg)
            2'd0:    limb = m_reg[DATA_W-1:0];
            2'd1:    limb = m_reg[2*DATA_W-1:DATA_W];
            default: limb = m_reg[3*DATA_W-1:2*DATA_W];
        endcase
    end

    assign limb_signed = (limb_reg == 2'd2) || (step_reg == 2'd0);
    assign limb_ext    = {limb_signed & limb[DATA_W-1], limb};
    assign product     = limb_ext * x;
    assign prod_ext    = ACC_W'(prod_reg);

    always_comb
    begin
        case (limb_reg)
            2'd0:    addend = prod_ext;
            2'd1:    addend = prod_ext << DATA_W;
            default: addend = prod_ext << (2 * DATA_W);
        endcase
    end

    assign sum       = r_reg + addend;
    assign last_limb = (step_reg == 2'd0) ? 2'd0 : 2'd2;
    assign init_b    = ACC_W'(coef_b) <<< FRAC_BITS;
    assign init_c    = ACC_W'(coef_c) <<< (2 * FRAC_BITS);
    assign init_d    = ACC_W'(coef_d) <<< (3 * FRAC_BITS);

    // Round half up, then saturate to the output width.
    assign rnd  = r_reg + ROUND_HALF;
    assign fits = (&rnd[ACC_W-1:RND_LSB+VALUE_W-1]) || !(|rnd[ACC_W-1:RND_LSB+VALUE_W-1]);

    always_comb
    begin
        if (fits)
        begin
            value = rnd[RND_LSB+VALUE_W-1:RND_LSB];
        end
        else if (rnd[ACC_W-1])
        begin
            value = SAT_MIN;
        end
        else
        begin
            value = SAT_MAX;
        end
    end

    assign overflowed = !fits;
    assign done       = (state_reg == C_RND) && out_free;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        limb_next  = limb_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    m_next     = H_W'(coef_a);
                    r_next     = init_b;
                    step_next  = 2'd0;
                    limb_next  = 2'd0;
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                state_next = C_ADD;
            end
            C_ADD:
            begin
                r_next     = sum;
                state_next = C_MUL;
                if (limb_reg == last_limb)
                begin
                    if (step_reg == 2'd2)
                    begin
                        state_next = C_RND;
                    end
                    else
                    begin
                        // Fold the finished Horner step back in as the next multiplicand.
                        m_next    = sum[H_W-1:0];
                        r_next    = (step_reg == 2'd0) ? init_c : init_d;
                        step_next = step_reg + 2'd1;
                        limb_next = 2'd0;
                    end
                end
                else
                begin
                    limb_next = limb_reg + 2'd1;
                end
            end
            C_RND:
            begin
                if (out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= 2'd0;
            limb_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            limb_reg  <= limb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        r_reg <= r_next;
        if (state_reg == C_MUL)
        begin
            prod_reg <= product;
        end
    end

    `PCE_ASSERT_NXT(a_mul_then_add, clk, rst_n, state_reg == C_MUL, state_reg == C_ADD)
    `PCE_ASSERT_IMP(a_limb_range, clk, rst_n, state_reg != C_IDLE, limb_reg != 2'd3 && step_reg != 2'd3)
    `PCE_ASSERT_IMP(a_first_step_one_limb, clk, rst_n, state_reg == C_ADD && step_reg == 2'd0, limb_reg == 2'd0)

endmodule
